/* sv/emde_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emde_pkg: shared types and constants
// Record layout, action and result codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package emde_pkg;

  localparam int MAX_ENTITIES = 256;
  localparam int SLOT_W       = $clog2(MAX_ENTITIES);
  localparam int POS_W        = 41;
  localparam int ANG_W        = 8;
  localparam int TICK_W       = 32;
  localparam int DELTA_W      = 16;
  localparam int DIFF_W       = POS_W + 1;
  localparam int IVL_W        = 16;

  localparam logic [IVL_W-1:0] RESYNC_RESET = IVL_W'(60);

  typedef enum logic [1:0] {
    ACT_ENCODE  = 2'd0,
    ACT_JOIN    = 2'd1,
    ACT_RESPAWN = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_SYNC     = 3'd1,
    KIND_MOVE_ROT = 3'd2,
    KIND_MOVE     = 3'd3,
    KIND_ROT      = 3'd4
  } kind_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [ANG_W-1:0]        yaw;
    logic [ANG_W-1:0]        pitch;
    logic [TICK_W-1:0]       sync_tick;
  } entity_rec_t;

  typedef struct packed {
    logic capture;  // latch item, read record
    logic calc;     // register differences
    logic commit;   // write record, register result
  } dp_cmd_t;

endpackage

/* sv/emde_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emde_ctrl: sequencing controller
// Steps one item through capture, difference and commit, and strobes done.
// ----------------------------------------------------------------------------
module emde_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output emde_pkg::dp_cmd_t cmd
);
  import emde_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state != ST_IDLE);
  assign cmd.capture = (state == ST_IDLE) && start;
  assign cmd.calc    = (state == ST_CALC);
  assign cmd.commit  = (state == ST_DECIDE);

endmodule

/* sv/emde_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emde_dp: encoder datapath
// Per-slot record memory, position and tick differences, sync decision and
// the registered result.
// ----------------------------------------------------------------------------
module emde_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  emde_pkg::dp_cmd_t                    cmd,
  input  logic                                 cfg_we,
  input  logic [emde_pkg::IVL_W-1:0]           cfg_wdata,
  input  logic [1:0]                           action,
  input  logic [7:0]                           entity_slot,
  input  logic signed [emde_pkg::POS_W-1:0]    pos_x,
  input  logic signed [emde_pkg::POS_W-1:0]    pos_y,
  input  logic signed [emde_pkg::POS_W-1:0]    pos_z,
  input  logic [emde_pkg::ANG_W-1:0]           yaw_in,
  input  logic [emde_pkg::ANG_W-1:0]           pitch_in,
  input  logic [emde_pkg::TICK_W-1:0]          tick_now,
  input  logic                                 has_viewers,
  input  logic                                 grounded,
  output logic [2:0]                           kind,
  output logic signed [emde_pkg::DELTA_W-1:0]  delta_x,
  output logic signed [emde_pkg::DELTA_W-1:0]  delta_y,
  output logic signed [emde_pkg::DELTA_W-1:0]  delta_z,
  output logic signed [emde_pkg::POS_W-1:0]    abs_x,
  output logic signed [emde_pkg::POS_W-1:0]    abs_y,
  output logic signed [emde_pkg::POS_W-1:0]    abs_z,
  output logic [emde_pkg::ANG_W-1:0]           yaw_out,
  output logic [emde_pkg::ANG_W-1:0]           pitch_out,
  output logic                                 grounded_out,
  output logic                                 head_turn
);
  import emde_pkg::*;

  entity_rec_t mem [MAX_ENTITIES];

  logic [IVL_W-1:0] resync_interval;

  // captured item
  action_t           act;
  logic [SLOT_W-1:0] slot;
  logic              slot_ok;
  entity_rec_t       item;
  logic              viewers;
  logic              gnd;
  entity_rec_t       last;

  // difference stage
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dz;
  logic [TICK_W-1:0]        dtick;
  logic                     rot_chg;

  logic        pos_chg;
  logic        fits;
  logic        due;
  logic        sync;
  logic        emit;
  logic        wr_en;
  entity_rec_t wr_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      resync_interval <= RESYNC_RESET;
    end else if (cfg_we) begin
      resync_interval <= cfg_wdata;
    end
  end

  // record memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= wr_rec;
    end
    if (cmd.capture) begin
      last <= mem[entity_slot[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act            <= action_t'(action);
      slot           <= entity_slot[SLOT_W-1:0];
      slot_ok        <= (32'(entity_slot) < MAX_ENTITIES);
      item.x         <= pos_x;
      item.y         <= pos_y;
      item.z         <= pos_z;
      item.yaw       <= yaw_in;
      item.pitch     <= pitch_in;
      item.sync_tick <= tick_now;
      viewers        <= has_viewers;
      gnd            <= grounded;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      dx      <= DIFF_W'(item.x) - DIFF_W'(last.x);
      dy      <= DIFF_W'(item.y) - DIFF_W'(last.y);
      dz      <= DIFF_W'(item.z) - DIFF_W'(last.z);
      dtick   <= item.sync_tick - last.sync_tick;
      rot_chg <= (item.yaw != last.yaw) || (item.pitch != last.pitch);
    end
  end

  // a delta fits 16 bits when its upper bits all copy the sign
  always_comb begin
    pos_chg = (dx != '0) || (dy != '0) || (dz != '0);
    fits    = ((&dx[DIFF_W-1:DELTA_W-1]) || !(|dx[DIFF_W-1:DELTA_W-1])) &&
              ((&dy[DIFF_W-1:DELTA_W-1]) || !(|dy[DIFF_W-1:DELTA_W-1])) &&
              ((&dz[DIFF_W-1:DELTA_W-1]) || !(|dz[DIFF_W-1:DELTA_W-1]));
    due     = (dtick >= TICK_W'(resync_interval));
    sync    = pos_chg && (!fits || due);
    emit    = (act == ACT_ENCODE) && slot_ok && viewers && (pos_chg || rot_chg);
    wr_en   = cmd.commit && slot_ok && (act != ACT_NONE);

    wr_rec  = item;
    case (act)
      ACT_ENCODE:  wr_rec.sync_tick = sync ? item.sync_tick : last.sync_tick;
      ACT_JOIN:    wr_rec.sync_tick = '0;
      ACT_RESPAWN: wr_rec.sync_tick = last.sync_tick;
      default:     wr_rec.sync_tick = last.sync_tick;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      kind         <= KIND_NONE;
      delta_x      <= '0;
      delta_y      <= '0;
      delta_z      <= '0;
      abs_x        <= '0;
      abs_y        <= '0;
      abs_z        <= '0;
      yaw_out      <= '0;
      pitch_out    <= '0;
      grounded_out <= 1'b0;
      head_turn    <= 1'b0;
      if (emit) begin
        grounded_out <= gnd;
        head_turn    <= rot_chg;
        if (sync) begin
          kind      <= KIND_SYNC;
          abs_x     <= item.x;
          abs_y     <= item.y;
          abs_z     <= item.z;
          yaw_out   <= item.yaw;
          pitch_out <= item.pitch;
        end else begin
          if (pos_chg) begin
            kind    <= rot_chg ? KIND_MOVE_ROT : KIND_MOVE;
            delta_x <= dx[DELTA_W-1:0];
            delta_y <= dy[DELTA_W-1:0];
            delta_z <= dz[DELTA_W-1:0];
          end else begin
            kind <= KIND_ROT;
          end
          if (rot_chg) begin
            yaw_out   <= item.yaw;
            pitch_out <= item.pitch;
          end
        end
      end
    end
  end

endmodule

/* sv/entity_move_delta_encoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entity_move_delta_encoder_top: entity movement delta encoder
// Per-slot last-seen position and angles; emits relative moves or an
// absolute sync when a move's delta overflows or the resync interval has passed.
// ----------------------------------------------------------------------------
//  Channel   | Handshake             | Signals
//  ----------+-----------------------+------------------------------------------
//  item in   | start & !busy         | action, entity_slot, pos_*, yaw_in, ...
//  result    | done (one cycle)      | kind, delta_*, abs_*, yaw_out, ...
//  config    | cfg_we                | cfg_wdata (resync_interval)
//
//  Each item steps through record read, differences, then commit. done rises
//  the cycle after commit, and a new item may be accepted while it shows;
//  while busy is high, no new item is taken.
//  Every accepted item gives exactly one result (kind 0 when nothing is sent).
//  rst is synchronous; the record memory is not cleared. The receiver cannot
//  stall.
// ----------------------------------------------------------------------------
module entity_move_delta_encoder_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  output logic                                 done,
  input  logic                                 cfg_we,
  input  logic [emde_pkg::IVL_W-1:0]           cfg_wdata,
  input  logic [1:0]                           action,
  input  logic [7:0]                           entity_slot,
  input  logic signed [emde_pkg::POS_W-1:0]    pos_x,
  input  logic signed [emde_pkg::POS_W-1:0]    pos_y,
  input  logic signed [emde_pkg::POS_W-1:0]    pos_z,
  input  logic [emde_pkg::ANG_W-1:0]           yaw_in,
  input  logic [emde_pkg::ANG_W-1:0]           pitch_in,
  input  logic [emde_pkg::TICK_W-1:0]          tick_now,
  input  logic                                 has_viewers,
  input  logic                                 grounded,
  output logic [2:0]                           kind,
  output logic signed [emde_pkg::DELTA_W-1:0]  delta_x,
  output logic signed [emde_pkg::DELTA_W-1:0]  delta_y,
  output logic signed [emde_pkg::DELTA_W-1:0]  delta_z,
  output logic signed [emde_pkg::POS_W-1:0]    abs_x,
  output logic signed [emde_pkg::POS_W-1:0]    abs_y,
  output logic signed [emde_pkg::POS_W-1:0]    abs_z,
  output logic [emde_pkg::ANG_W-1:0]           yaw_out,
  output logic [emde_pkg::ANG_W-1:0]           pitch_out,
  output logic                                 grounded_out,
  output logic                                 head_turn
);
  import emde_pkg::*;

  dp_cmd_t cmd;

  emde_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  emde_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .action       (action),
    .entity_slot  (entity_slot),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .yaw_in       (yaw_in),
    .pitch_in     (pitch_in),
    .tick_now     (tick_now),
    .has_viewers  (has_viewers),
    .grounded     (grounded),
    .kind         (kind),
    .delta_x      (delta_x),
    .delta_y      (delta_y),
    .delta_z      (delta_z),
    .abs_x        (abs_x),
    .abs_y        (abs_y),
    .abs_z        (abs_z),
    .yaw_out      (yaw_out),
    .pitch_out    (pitch_out),
    .grounded_out (grounded_out),
    .head_turn    (head_turn)
  );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: entity movement delta encoder
// Drives join, respawn, encode and unused-action transfers into the block and
// checks every result against a cycle-free predictor of the per-slot records.
// A directed table covers extremes, overflow, resync and tick wrap; random
// traffic follows under several resync intervals, with bursts of idle cycles.
// ----------------------------------------------------------------------------
module testbench;
  import emde_pkg::*;

  localparam int  LIMIT_CYCLES = 200000;
  localparam int  PHASES       = 5;
  localparam int  PHASE_ITEMS  = 200;
  localparam int  MAX_ERR_LINES = 100;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef struct packed {
    action_t                 act;
    logic [SLOT_W-1:0]       slot;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [ANG_W-1:0]        yaw;
    logic [ANG_W-1:0]        pitch;
    logic [TICK_W-1:0]       tick;
    logic                    viewers;
    logic                    grounded;
  } move_item_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [DELTA_W-1:0] dz;
    logic signed [POS_W-1:0]   ax;
    logic signed [POS_W-1:0]   ay;
    logic signed [POS_W-1:0]   az;
    logic [ANG_W-1:0]          yaw;
    logic [ANG_W-1:0]          pitch;
    logic                      grounded;
    logic                      head;
  } move_msg_t;

  typedef struct packed {
    move_item_t it;
    logic       typed;
    move_msg_t  want;
  } dir_row_t;

  localparam move_msg_t NO_MSG = '0;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      done;
  logic                      cfg_we = 1'b0;
  logic [IVL_W-1:0]          cfg_wdata = '0;
  logic [1:0]                action = ACT_NONE;
  logic [7:0]                entity_slot = '0;
  logic signed [POS_W-1:0]   pos_x = '0;
  logic signed [POS_W-1:0]   pos_y = '0;
  logic signed [POS_W-1:0]   pos_z = '0;
  logic [ANG_W-1:0]          yaw_in = '0;
  logic [ANG_W-1:0]          pitch_in = '0;
  logic [TICK_W-1:0]         tick_now = '0;
  logic                      has_viewers = 1'b0;
  logic                      grounded = 1'b0;
  logic [2:0]                kind;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;
  logic signed [DELTA_W-1:0] delta_z;
  logic signed [POS_W-1:0]   abs_x;
  logic signed [POS_W-1:0]   abs_y;
  logic signed [POS_W-1:0]   abs_z;
  logic [ANG_W-1:0]          yaw_out;
  logic [ANG_W-1:0]          pitch_out;
  logic                      grounded_out;
  logic                      head_turn;

  // predictor state
  entity_rec_t       track [MAX_ENTITIES];
  bit                joined [MAX_ENTITIES];
  logic [IVL_W-1:0]  resync_ivl = RESYNC_RESET;
  logic [TICK_W-1:0] tick_cur = '0;
  logic [SLOT_W-1:0] slot_pool [8];

  move_msg_t pending_moves [$];
  dir_row_t  dir_rows [$];
  int        errors = 0;
  int        cycles = 0;

  entity_move_delta_encoder_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .action       (action),
    .entity_slot  (entity_slot),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .yaw_in       (yaw_in),
    .pitch_in     (pitch_in),
    .tick_now     (tick_now),
    .has_viewers  (has_viewers),
    .grounded     (grounded),
    .kind         (kind),
    .delta_x      (delta_x),
    .delta_y      (delta_y),
    .delta_z      (delta_z),
    .abs_x        (abs_x),
    .abs_y        (abs_y),
    .abs_z        (abs_z),
    .yaw_out      (yaw_out),
    .pitch_out    (pitch_out),
    .grounded_out (grounded_out),
    .head_turn    (head_turn)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (errors < MAX_ERR_LINES) $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic bit in16(input logic signed [DIFF_W-1:0] d);
    return (&d[DIFF_W-1:DELTA_W-1]) || !(|d[DIFF_W-1:DELTA_W-1]);
  endfunction

  // Expected result of one accepted transfer; updates the slot records.
  function automatic move_msg_t encode_move(input move_item_t it);
    move_msg_t                m;
    entity_rec_t              rec;
    logic signed [DIFF_W-1:0] ddx, ddy, ddz;
    logic [TICK_W-1:0]        since;
    bit                       moved, turned, resync;
    m = NO_MSG;
    if (it.act == ACT_NONE) return m;
    rec = track[it.slot];
    track[it.slot].x     = it.x;
    track[it.slot].y     = it.y;
    track[it.slot].z     = it.z;
    track[it.slot].yaw   = it.yaw;
    track[it.slot].pitch = it.pitch;
    if (it.act != ACT_ENCODE) begin
      if (it.act == ACT_JOIN) track[it.slot].sync_tick = '0;
      return m;
    end
    ddx    = {it.x[POS_W-1], it.x} - {rec.x[POS_W-1], rec.x};
    ddy    = {it.y[POS_W-1], it.y} - {rec.y[POS_W-1], rec.y};
    ddz    = {it.z[POS_W-1], it.z} - {rec.z[POS_W-1], rec.z};
    moved  = (ddx != '0) || (ddy != '0) || (ddz != '0);
    turned = (it.yaw != rec.yaw) || (it.pitch != rec.pitch);
    since  = it.tick - rec.sync_tick;
    resync = moved && (!(in16(ddx) && in16(ddy) && in16(ddz)) ||
                       since >= TICK_W'(resync_ivl));
    if (resync) track[it.slot].sync_tick = it.tick;
    if (!it.viewers || !(moved || turned)) return m;
    if (resync) begin
      m.kind  = KIND_SYNC;
      m.ax    = it.x;
      m.ay    = it.y;
      m.az    = it.z;
      m.yaw   = it.yaw;
      m.pitch = it.pitch;
    end else begin
      m.kind = moved ? (turned ? KIND_MOVE_ROT : KIND_MOVE) : KIND_ROT;
      if (moved) begin
        m.dx = ddx[DELTA_W-1:0];
        m.dy = ddy[DELTA_W-1:0];
        m.dz = ddz[DELTA_W-1:0];
      end
      if (turned) begin
        m.yaw   = it.yaw;
        m.pitch = it.pitch;
      end
    end
    m.grounded = it.grounded;
    m.head     = turned;
    return m;
  endfunction

  function automatic move_item_t mk_item(input action_t act, input int slot,
      input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
      input logic signed [POS_W-1:0] z, input int yaw, input int pitch,
      input logic [TICK_W-1:0] tick, input bit viewers, input bit gnd);
    move_item_t it;
    it.act      = act;
    it.slot     = SLOT_W'(slot);
    it.x        = x;
    it.y        = y;
    it.z        = z;
    it.yaw      = ANG_W'(yaw);
    it.pitch    = ANG_W'(pitch);
    it.tick     = tick;
    it.viewers  = viewers;
    it.grounded = gnd;
    return it;
  endfunction

  function automatic move_msg_t mk_msg(input kind_t k, input int dx, input int dy,
      input int dz, input logic signed [POS_W-1:0] ax,
      input logic signed [POS_W-1:0] ay, input logic signed [POS_W-1:0] az,
      input int yaw, input int pitch, input bit gnd, input bit head);
    move_msg_t m;
    m.kind     = k;
    m.dx       = DELTA_W'(dx);
    m.dy       = DELTA_W'(dy);
    m.dz       = DELTA_W'(dz);
    m.ax       = ax;
    m.ay       = ay;
    m.az       = az;
    m.yaw      = ANG_W'(yaw);
    m.pitch    = ANG_W'(pitch);
    m.grounded = gnd;
    m.head     = head;
    return m;
  endfunction

  function automatic void add_row(input move_item_t it, input logic typed,
                                  input move_msg_t want);
    dir_row_t r;
    r.it    = it;
    r.typed = typed;
    r.want  = want;
    dir_rows = {dir_rows, r};
  endfunction

  function automatic logic signed [POS_W-1:0] next_coord(
      input logic signed [POS_W-1:0] prev);
    int mode;
    int step;
    mode = $urandom_range(0, 99);
    if (mode < 30) return prev;
    if (mode < 40) return POS_W'({$urandom(), $urandom()});
    if (mode < 85) step = int'($urandom_range(0, 4000)) - 2000;
    else step = ($urandom_range(0, 1) != 0 ? 1 : -1) * int'($urandom_range(32760, 32775));
    return prev + POS_W'(step);
  endfunction

  // Mostly encodes on a few joined slots; joins first where a slot is fresh.
  function automatic move_item_t next_random_item();
    move_item_t  it;
    entity_rec_t rec;
    int          pick;
    it = '0;
    it.slot = ($urandom_range(0, 99) < 85) ? slot_pool[$urandom_range(0, 7)]
                                           : SLOT_W'($urandom_range(0, 255));
    tick_cur += ($urandom_range(0, 99) < 5) ? $urandom() : $urandom_range(0, 25);
    it.tick     = tick_cur;
    it.viewers  = ($urandom_range(0, 9) != 0);
    it.grounded = 1'($urandom_range(0, 1));
    rec  = track[it.slot];
    pick = $urandom_range(0, 99);
    if (!joined[it.slot] || pick < 4) it.act = ACT_JOIN;
    else if (pick < 9) it.act = ACT_RESPAWN;
    else if (pick < 12) it.act = ACT_NONE;
    else it.act = ACT_ENCODE;
    if (!joined[it.slot]) begin
      it.x = POS_W'({$urandom(), $urandom()});
      it.y = POS_W'({$urandom(), $urandom()});
      it.z = POS_W'({$urandom(), $urandom()});
    end else begin
      it.x = next_coord(rec.x);
      it.y = next_coord(rec.y);
      it.z = next_coord(rec.z);
    end
    it.yaw   = ($urandom_range(0, 1) != 0) ? rec.yaw : ANG_W'($urandom_range(0, 255));
    it.pitch = ($urandom_range(0, 1) != 0) ? rec.pitch : ANG_W'($urandom_range(0, 255));
    if (it.act == ACT_JOIN) joined[it.slot] = 1'b1;
    return it;
  endfunction

  // Hold start until the transfer is taken; the caller lowers it when idling.
  task automatic send_item(input move_item_t it, input logic typed,
                           input move_msg_t want);
    move_msg_t m;
    start       <= 1'b1;
    action      <= it.act;
    entity_slot <= it.slot;
    pos_x       <= it.x;
    pos_y       <= it.y;
    pos_z       <= it.z;
    yaw_in      <= it.yaw;
    pitch_in    <= it.pitch;
    tick_now    <= it.tick;
    has_viewers <= it.viewers;
    grounded    <= it.grounded;
    do @(posedge clk); while (busy);
    m = encode_move(it);
    pending_moves = {pending_moves, (typed ? want : m)};
  endtask

  task automatic write_interval(input logic [IVL_W-1:0] ivl);
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ivl;
    @(posedge clk);
    cfg_we     <= 1'b0;
    resync_ivl = ivl;
  endtask

  always @(posedge clk) begin
    move_msg_t want;
    if (!rst && done) begin
      if (pending_moves.size() == 0) begin
        report_mismatch("result with no transfer waiting");
      end else begin
        want = pending_moves.pop_front();
        check_field("kind", kind, want.kind);
        check_field("delta_x", delta_x, want.dx);
        check_field("delta_y", delta_y, want.dy);
        check_field("delta_z", delta_z, want.dz);
        check_field("abs_x", abs_x, want.ax);
        check_field("abs_y", abs_y, want.ay);
        check_field("abs_z", abs_z, want.az);
        check_field("yaw_out", yaw_out, want.yaw);
        check_field("pitch_out", pitch_out, want.pitch);
        check_field("grounded_out", grounded_out, want.grounded);
        check_field("head_turn", head_turn, want.head);
      end
    end
  end

  initial begin
    int               idle_pct;
    logic [IVL_W-1:0] plan [PHASES];

    plan[0] = RESYNC_RESET;
    plan[1] = IVL_W'(1);
    plan[2] = '1;
    plan[3] = '0;
    plan[4] = IVL_W'($urandom_range(2, 200));
    for (int i = 0; i < MAX_ENTITIES; i++) begin
      track[i]  = '0;
      joined[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) slot_pool[i] = SLOT_W'($urandom_range(0, 255));
    tick_cur = $urandom();

    // unused action, loads, no change, int16 edges, overflow and interval resync
    add_row(mk_item(ACT_NONE, 5, 0, 0, 0, 0, 0, 0, 1, 1), 1'b1, NO_MSG);
    add_row(mk_item(ACT_JOIN, 0, 0, 0, 0, 0, 0, 0, 1, 1), 1'b1, NO_MSG);
    add_row(mk_item(ACT_ENCODE, 0, 0, 0, 0, 0, 0, 10, 1, 1), 1'b1, NO_MSG);
    add_row(mk_item(ACT_ENCODE, 0, 32767, -32768, 0, 0, 0, 10, 1, 1), 1'b1,
            mk_msg(KIND_MOVE, 32767, -32768, 0, 0, 0, 0, 0, 0, 1, 0));
    add_row(mk_item(ACT_ENCODE, 0, 32767, -32768, 0, 255, 255, 11, 1, 0),
            1'b1, mk_msg(KIND_ROT, 0, 0, 0, 0, 0, 0, 255, 255, 0, 1));
    add_row(mk_item(ACT_ENCODE, 0, 65535, -32768, 0, 255, 255, 12, 1, 1),
            1'b1,
            mk_msg(KIND_SYNC, 0, 0, 0, 65535, -32768, 0, 255, 255, 1, 0));
    add_row(mk_item(ACT_ENCODE, 0, 65535, -32768, 1, 255, 255, 71, 1, 0),
            1'b1, mk_msg(KIND_MOVE, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_item(ACT_ENCODE, 0, 65535, -32768, 2, 255, 255, 72, 1, 1),
            1'b1,
            mk_msg(KIND_SYNC, 0, 0, 0, 65535, -32768, 2, 255, 255, 1, 0));
    // no viewers: silent, but the record and sync tick still move on
    add_row(mk_item(ACT_ENCODE, 0, 0, -32768, 2, 7, 255, 73, 0, 1), 1'b1,
            NO_MSG);
    add_row(mk_item(ACT_ENCODE, 0, 0, -32768, 3, 8, 255, 74, 1, 1), 1'b0,
            NO_MSG);
    add_row(mk_item(ACT_JOIN, 255, POS_MAX, POS_MIN, POS_MAX, 128, 64, 5,
                    1, 0), 1'b1, NO_MSG);
    add_row(mk_item(ACT_ENCODE, 255, POS_MIN, POS_MAX, POS_MIN, 128, 64,
                    32'hFFFF_FFFF, 1, 1), 1'b1,
            mk_msg(KIND_SYNC, 0, 0, 0, POS_MIN, POS_MAX, POS_MIN, 128, 64,
                   1, 0));
    // respawn keeps the sync tick, so the next ticks wrap past zero
    add_row(mk_item(ACT_RESPAWN, 255, 0, 0, 0, 0, 0, 0, 1, 1), 1'b1,
            NO_MSG);
    add_row(mk_item(ACT_ENCODE, 255, 1, 0, 0, 0, 0, 58, 1, 0), 1'b0, NO_MSG);
    add_row(mk_item(ACT_ENCODE, 255, 2, 0, 0, 0, 0, 59, 1, 1), 1'b0, NO_MSG);
    add_row(mk_item(ACT_ENCODE, 255, 2, -1, 0, 1, 0, 60, 1, 1), 1'b0, NO_MSG);
    add_row(mk_item(ACT_JOIN, 0, 100, 0, 0, 0, 0, 99, 1, 1), 1'b1, NO_MSG);
    add_row(mk_item(ACT_ENCODE, 0, 105, 0, 0, 0, 0, 100, 1, 1), 1'b0, NO_MSG);
    add_row(mk_item(ACT_ENCODE, 0, 106, 0, 0, 0, 0, 101, 0, 0), 1'b1, NO_MSG);
    add_row(mk_item(ACT_ENCODE, 0, 106, -4000, 50, 3, 200, 102, 1, 1), 1'b0,
            NO_MSG);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    joined[0]   = 1'b1;
    joined[255] = 1'b1;

    idle_pct = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        start <= 1'b0;
        write_interval(plan[ph]);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
        // no idling in the last phase
        if (ph < PHASES - 1 && $urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        send_item(next_random_item(), 1'b0, NO_MSG);
      end
    end
    start <= 1'b0;

    while (pending_moves.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/emde_pkg.sv
sv/emde_ctrl.sv
sv/emde_dp.sv
sv/entity_move_delta_encoder_top.sv
test/testbench.sv
